### sv/modular_exponentiation_fixed_prime_top_macros.svh
// assertion macros shared by the modular exponentiation block
// no dependencies; taken in by the top level
`ifndef MODULAR_EXPONENTIATION_FIXED_PRIME_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_FIXED_PRIME_TOP_MACROS_SVH

// same-cycle implication, checked while reset is low
`define MODEXP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("modexp check failed");

// next-cycle implication, checked while reset is low
`define MODEXP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("modexp check failed");

`endif

### sv/modexp_pkg.sv
// shared types, constants and the microcode table of the modular exponentiation block
// no dependencies
package modexp_pkg;

   localparam logic [29:0] PRIME_MOD = 30'd998244353;
   // floor(2^60 / prime), fits in 31 bits
   localparam logic [30:0] BARRETT_MU = 31'(64'h1000_0000_0000_0000 / 64'd998244353);

   localparam int unsigned UPC_W = 4;

   localparam logic [UPC_W-1:0] STEP_IDLE   = UPC_W'(0);
   localparam logic [UPC_W-1:0] STEP_MUL    = UPC_W'(1);
   localparam logic [UPC_W-1:0] STEP_SQR    = UPC_W'(2);
   localparam logic [UPC_W-1:0] STEP_WAIT_A = UPC_W'(3);
   localparam logic [UPC_W-1:0] STEP_WAIT_B = UPC_W'(4);
   localparam logic [UPC_W-1:0] STEP_WAIT_C = UPC_W'(5);
   localparam logic [UPC_W-1:0] STEP_WAIT_D = UPC_W'(6);
   localparam logic [UPC_W-1:0] STEP_TEST   = UPC_W'(7);
   localparam logic [UPC_W-1:0] STEP_DONE   = UPC_W'(8);

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_REQ,
      COND_EXP_NZ,
      COND_OUT_FREE
   } cond_type;

   // which register a modular product lands in
   typedef struct packed {
      logic wr_acc;
      logic wr_bas;
   } tag_type;

   typedef struct packed {
      logic req_valid;
      logic exp_nz;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic             take_req;
      logic             issue_mul;
      logic             issue_sqr;
      logic             shift_exp;
      logic             emit;
      cond_type         cond;
      logic             hold;
      logic [UPC_W-1:0] target;
   } uword_type;

   // control store: jump to target when cond holds, else hold or advance
   function automatic uword_type ucode_word(input logic [UPC_W-1:0] upc);
      uword_type w;
      w = '0;
      unique case (upc)
         STEP_IDLE: begin
            w.take_req = 1'b1;
            w.cond     = COND_REQ;
            w.target   = STEP_MUL;
            w.hold     = 1'b1;
         end
         STEP_MUL: begin
            w.issue_mul = 1'b1;
         end
         STEP_SQR: begin
            w.issue_sqr = 1'b1;
            w.shift_exp = 1'b1;
         end
         STEP_WAIT_A, STEP_WAIT_B, STEP_WAIT_C, STEP_WAIT_D: begin
            w.cond = COND_NEVER;
         end
         STEP_TEST: begin
            w.cond   = COND_EXP_NZ;
            w.target = STEP_MUL;
         end
         STEP_DONE: begin
            w.emit   = 1'b1;
            w.cond   = COND_OUT_FREE;
            w.target = STEP_IDLE;
            w.hold   = 1'b1;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

### sv/modular_exponentiation_fixed_prime_top.sv
// per exponent bit the sequencer issues a multiply and a square back to back into the five-stage
// modular multiplier, waits for both products, then tests the shifted exponent; it scans up to the
// highest set exponent bit (a single pass for a zero exponent), then emits the result, and it takes
// no new request until that result has been moved into the output register
// reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid
// depends on modexp_pkg, modexp_mulmod, modexp_useq and the assertion macro header
`include "modular_exponentiation_fixed_prime_top_macros.svh"

module modular_exponentiation_fixed_prime_top #(
   parameter int EXP_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [29:0] req_base_value,
   input  logic [31:0] req_exponent_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [29:0] rsp_power_result
);

   // only the low EXP_BITS bits of the exponent are scanned
   localparam logic [31:0] EXP_MASK = (EXP_BITS >= 32) ? 32'hFFFF_FFFF
                                      : 32'((64'd1 << EXP_BITS) - 64'd1);

   modexp_pkg::uword_type  uword;
   modexp_pkg::status_type status;
   modexp_pkg::tag_type    issue_tag, wb_tag;

   logic [29:0] acc_ff, acc_in;
   logic [29:0] bas_ff, bas_in;
   logic [31:0] exp_ff, exp_in;
   logic [29:0] op_a;
   logic [29:0] wb_value;
   logic [29:0] base_red;
   logic        req_xfer;
   logic        out_free;
   logic        emit_fire;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [29:0] rsp_power_result_ff, rsp_power_result_in;

   modexp_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .uword  (uword)
   );

   modexp_mulmod u_mulmod (
      .clock     (clock),
      .reset     (reset),
      .issue_tag (issue_tag),
      .op_a      (op_a),
      .op_b      (bas_ff),
      .wb_tag    (wb_tag),
      .wb_value  (wb_value)
   );

   assign req_ready = uword.take_req;
   assign req_xfer  = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign emit_fire = uword.emit & out_free;

   assign status.req_valid = req_valid;
   assign status.exp_nz    = |exp_ff;
   assign status.out_free  = out_free;

   // a base at or above the prime needs one subtraction
   assign base_red = (req_base_value >= modexp_pkg::PRIME_MOD)
                     ? req_base_value - modexp_pkg::PRIME_MOD : req_base_value;

   // multiply step folds the base in when the low exponent bit is set
   assign issue_tag.wr_acc = uword.issue_mul & exp_ff[0];
   assign issue_tag.wr_bas = uword.issue_sqr;
   assign op_a             = uword.issue_mul ? acc_ff : bas_ff;

   always_comb begin
      priority if (req_xfer) begin
         acc_in = 30'd1;
         bas_in = base_red;
         exp_in = req_exponent_value & EXP_MASK;
      end else begin
         acc_in = wb_tag.wr_acc ? wb_value : acc_ff;
         bas_in = wb_tag.wr_bas ? wb_value : bas_ff;
         exp_in = uword.shift_exp ? (exp_ff >> 1) : exp_ff;
      end
   end

   always_comb begin
      rsp_power_result_in = emit_fire ? acc_ff : rsp_power_result_ff;
      priority if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff              <= acc_in;
      bas_ff              <= bas_in;
      exp_ff              <= exp_in;
      rsp_power_result_ff <= rsp_power_result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_power_result_ff;

   `MODEXP_ASSERT_SAME(a_rsp_reduced, clock, reset, rsp_valid, rsp_power_result < modexp_pkg::PRIME_MOD)
   `MODEXP_ASSERT_SAME(a_no_load_in_flight, clock, reset, wb_tag.wr_acc || wb_tag.wr_bas, !req_ready)
   `MODEXP_ASSERT_NEXT(a_one_item_at_once, clock, reset, req_valid && req_ready, !req_ready)

endmodule

### sv/modexp_mulmod.sv
// pipelined modular multiplier: product then barrett reduction, five register stages
// depends on modexp_pkg
module modexp_mulmod (
   input  logic                clock,
   input  logic                reset,
   input  modexp_pkg::tag_type issue_tag,
   input  logic [29:0]         op_a,
   input  logic [29:0]         op_b,
   output modexp_pkg::tag_type wb_tag,
   output logic [29:0]         wb_value
);

   logic [59:0] prod_ff, prod_in;
   logic [61:0] q2_ff, q2_in;
   logic [31:0] xlo2_ff, xlo3_ff;
   logic [60:0] qp_full;
   logic [31:0] qp_ff, qp_in;
   logic [31:0] r_ff, r_in;
   logic [30:0] r5_ff, r5_in;

   modexp_pkg::tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff;

   assign prod_in = op_a * op_b;
   // q1 = x >> 29, q3 = (q1 * mu) >> 31
   assign q2_in   = prod_ff[59:29] * modexp_pkg::BARRETT_MU;
   assign qp_full = q2_ff[61:31] * modexp_pkg::PRIME_MOD;
   assign qp_in   = qp_full[31:0];
   // true remainder is below three times the prime, so 32 bits hold it
   assign r_in    = xlo3_ff - qp_ff;
   assign r5_in   = (r_ff >= 32'(modexp_pkg::PRIME_MOD))
                    ? 31'(r_ff - 32'(modexp_pkg::PRIME_MOD)) : r_ff[30:0];

   assign wb_value = (r5_ff >= 31'(modexp_pkg::PRIME_MOD))
                     ? 30'(r5_ff - 31'(modexp_pkg::PRIME_MOD)) : r5_ff[29:0];
   assign wb_tag   = tag5_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      q2_ff   <= q2_in;
      xlo2_ff <= prod_ff[31:0];
      qp_ff   <= qp_in;
      xlo3_ff <= xlo2_ff;
      r_ff    <= r_in;
      r5_ff   <= r5_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
         tag5_ff <= '0;
      end else begin
         tag1_ff <= issue_tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
         tag5_ff <= tag4_ff;
      end
   end

endmodule

### sv/modexp_useq.sv
// microcode sequencer: step counter, control store lookup and conditional jumps
// depends on modexp_pkg
module modexp_useq (
   input  logic                   clock,
   input  logic                   reset,
   input  modexp_pkg::status_type status,
   output modexp_pkg::uword_type  uword
);

   logic [modexp_pkg::UPC_W-1:0] upc_ff, upc_in;
   logic                         jump;

   assign uword = modexp_pkg::ucode_word(upc_ff);

   always_comb begin
      unique case (uword.cond)
         modexp_pkg::COND_NEVER:    jump = 1'b0;
         modexp_pkg::COND_ALWAYS:   jump = 1'b1;
         modexp_pkg::COND_REQ:      jump = status.req_valid;
         modexp_pkg::COND_EXP_NZ:   jump = status.exp_nz;
         modexp_pkg::COND_OUT_FREE: jump = status.out_free;
         default:                   jump = 1'b0;
      endcase
   end

   always_comb begin
      priority if (jump) begin
         upc_in = uword.target;
      end else if (uword.hold) begin
         upc_in = upc_ff;
      end else begin
         upc_in = upc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= modexp_pkg::STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

### bench/modular_exponentiation_fixed_prime_top_tb.sv
// self-checking bench for modular_exponentiation_fixed_prime_top: base^exponent mod 998244353
// depends on modexp_pkg and the top level; the expected power is computed by square-and-multiply
module modular_exponentiation_fixed_prime_top_tb;

   localparam int WATCHDOG_LIMIT = 4000;
   // worst-case latency at 32 exponent bits plus margin
   localparam int DRAIN_CYCLES   = 260;
   localparam int RANDOM_JOBS    = 345;

   typedef struct {
      logic [29:0] base;
      logic [31:0] exponent;
   } power_job_type;

   logic        clock;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_ready;
   logic [29:0] req_base_value     = '0;
   logic [31:0] req_exponent_value = '0;
   logic        rsp_valid;
   logic        rsp_ready          = 1'b0;
   logic [29:0] rsp_power_result;

   power_job_type pending_jobs[$];
   logic [29:0]   expected_powers[$];
   logic          req_taken          = 1'b0;
   int            sender_idle_pct    = 0;
   int            receiver_idle_pct  = 0;
   int            jobs_queued        = 0;
   int            jobs_accepted      = 0;
   int            powers_checked     = 0;
   int            mismatch_count     = 0;
   int            quiet_cycles       = 0;
   int            directed_count     = 0;

   modular_exponentiation_fixed_prime_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_base_value     (req_base_value),
      .req_exponent_value (req_exponent_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_power_result   (rsp_power_result)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // left-to-right square-and-multiply over all 32 exponent bits
   function automatic logic [29:0] power_mod_prime(input logic [29:0] base,
                                                   input logic [31:0] exponent);
      logic [63:0] modulus;
      logic [63:0] residue;
      logic [63:0] acc;
      modulus = 64'(modexp_pkg::PRIME_MOD);
      residue = 64'(base) % modulus;
      acc     = 64'd1;
      for (int i = 31; i >= 0; i--) begin
         acc = (acc * acc) % modulus;
         if (exponent[i]) begin
            acc = (acc * residue) % modulus;
         end
      end
      return acc[29:0];
   endfunction

   function automatic power_job_type random_power_job();
      power_job_type job;
      int            pick;
      pick = $urandom_range(99);
      if (pick < 5) begin
         case ($urandom_range(2))
            0:       job.base = '0;
            1:       job.base = 30'd1;
            default: job.base = modexp_pkg::PRIME_MOD - 30'd1;
         endcase
      end else if (pick < 10) begin
         // bases at or above the modulus must be reduced first
         job.base = modexp_pkg::PRIME_MOD
                    + 30'($urandom_range(32'h3FFF_FFFF - 32'(modexp_pkg::PRIME_MOD)));
      end else begin
         job.base = 30'($urandom_range(32'(modexp_pkg::PRIME_MOD) - 1));
      end
      pick = $urandom_range(99);
      if (pick < 30) begin
         job.exponent = 32'($urandom_range(15));
      end else if (pick < 45) begin
         job.exponent = (32'd1 << $urandom_range(31)) | (32'd1 << $urandom_range(31));
      end else if (pick < 50) begin
         job.exponent = 32'(modexp_pkg::PRIME_MOD) - 32'($urandom_range(2, 1));
      end else begin
         job.exponent = $urandom;
      end
      return job;
   endfunction

   task automatic queue_job(input logic [29:0] base, input logic [31:0] exponent);
      power_job_type job;
      job.base     = base;
      job.exponent = exponent;
      pending_jobs.push_back(job);
      jobs_queued++;
   endtask

   // request and response-ready driver: changes on the falling edge only
   always @(negedge clock) begin
      power_job_type job;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (pending_jobs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               job = pending_jobs.pop_front();
               req_base_value     <= job.base;
               req_exponent_value <= job.exponent;
               req_valid          <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // monitor: predicts on request transfer, checks on result transfer
   always @(posedge clock) begin
      logic [29:0] expected;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_powers.push_back(power_mod_prime(req_base_value, req_exponent_value));
            jobs_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_powers.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected result %0d with nothing outstanding", rsp_power_result);
               end
            end else begin
               expected = expected_powers.pop_front();
               powers_checked++;
               if (rsp_power_result !== expected) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("power_result mismatch: expected %0d, got %0d",
                              expected, rsp_power_result);
                  end
               end
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         @(posedge clock);
         case (phase)
            0: begin
               sender_idle_pct   = 12;
               receiver_idle_pct = 61;
            end
            1: begin
               sender_idle_pct   = 61;
               receiver_idle_pct = 12;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         if (phase == 0) begin
            queue_job('0, '0);
            queue_job('0, 32'd1);
            queue_job('0, 32'hFFFF_FFFF);
            queue_job(30'd1, 32'hFFFF_FFFF);
            queue_job(30'd12345, '0);
            queue_job(modexp_pkg::PRIME_MOD - 30'd1, 32'd1);
            queue_job(modexp_pkg::PRIME_MOD - 30'd1, 32'd2);
            queue_job(modexp_pkg::PRIME_MOD - 30'd1, 32'hFFFF_FFFF);
            queue_job(30'd2, 32'h8000_0000);
            queue_job(30'd2, 32'd29);
            queue_job(30'd2, 32'd30);
            queue_job(30'd3, 32'(modexp_pkg::PRIME_MOD) - 32'd1);
            queue_job(30'd5, 32'(modexp_pkg::PRIME_MOD) - 32'd2);
            queue_job(30'h3FFF_FFFF, 32'd1);
            queue_job(30'h3FFF_FFFF, 32'hFFFF_FFFF);
            queue_job(modexp_pkg::PRIME_MOD, 32'd5);
            queue_job(modexp_pkg::PRIME_MOD, '0);
            queue_job(modexp_pkg::PRIME_MOD + 30'd1, 32'hFFFF_FFFF);
            queue_job(30'h2AAA_AAAA, 32'h5555_5555);
            queue_job(30'h1555_5555, 32'hAAAA_AAAA);
            queue_job(30'd7, 32'd1);
            directed_count = jobs_queued;
         end
         for (int n = 0; n < RANDOM_JOBS; n++) begin
            power_job_type job;
            job = random_power_job();
            queue_job(job.base, job.exponent);
         end
         // each phase waits until every queued job is accepted and every outstanding result is back
         do begin
            @(negedge clock);
         end while (pending_jobs.size() > 0 || jobs_accepted != jobs_queued
                    || expected_powers.size() > 0);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("%0d requests (%0d directed corners) and %0d results checked",
               jobs_accepted, directed_count, powers_checked);
      $display("under three stall mixes: light/heavy, heavy/light and back-to-back");
      if (mismatch_count == 0 && expected_powers.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results outstanding",
                  mismatch_count, expected_powers.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
